@@ hdl/bole_pkg.sv @@
// Package for the bounded ordered list engine: types, command codes and sizes.
`default_nettype none
package bole_pkg;

	// Default list capacity
	localparam int DEPTH_DEF = 16;

	// Depth of the queue between front and back (power of two)
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	// Command codes on the input port
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_SEARCH     = 3'd4;
	localparam logic [2:0] CMD_REMOVE     = 3'd5;

	// Classified operation
	typedef enum logic [2:0] {
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_SEARCH,
		OP_REMOVE,
		OP_NOP
	} op_t;

	// Result status
	typedef enum logic [1:0] {
		STAT_OK,
		STAT_FULL,
		STAT_EMPTY
	} status_t;

	// Back end sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// One queued item
	typedef struct packed {
		op_t         op;
		logic [31:0] value;
	} item_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic  vld;
		item_t item;
	} q_head_t;

endpackage
`default_nettype wire

@@ hdl/bole_front.sv @@
// Front end: accepts command beats and classifies them into queue items.
`default_nettype none
module bole_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire  [2:0]          command,
	input  wire  signed [31:0]  value,
	input  wire                 q_full,
	output logic                q_push,
	output bole_pkg::item_t     q_item
);

	logic            vld_s1;
	bole_pkg::item_t item_s1;
	logic            accept;
	bole_pkg::op_t   op;

	// Decode command code, unused codes become no-ops
	always_comb begin
		unique case (command)
			bole_pkg::CMD_PUSH_FRONT: op = bole_pkg::OP_PUSH_FRONT;
			bole_pkg::CMD_PUSH_BACK:  op = bole_pkg::OP_PUSH_BACK;
			bole_pkg::CMD_POP_FRONT:  op = bole_pkg::OP_POP_FRONT;
			bole_pkg::CMD_POP_BACK:   op = bole_pkg::OP_POP_BACK;
			bole_pkg::CMD_SEARCH:     op = bole_pkg::OP_SEARCH;
			bole_pkg::CMD_REMOVE:     op = bole_pkg::OP_REMOVE;
			default:                  op = bole_pkg::OP_NOP;
		endcase
	end

	// Stage drains into the queue whenever the queue has room
	assign q_push = vld_s1 && !q_full;
	assign busy   = vld_s1 && q_full;
	assign accept = start && !busy;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op    <= op;
			item_s1.value <= value;
		end
	end

endmodule
`default_nettype wire

@@ hdl/bole_queue.sv @@
// Short queue of classified items between the front and back ends.
`default_nettype none
module bole_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  bole_pkg::item_t     push_item,
	output logic                full,
	input  wire                 pop,
	output bole_pkg::q_head_t   head
);

	bole_pkg::item_t          slot_q [bole_pkg::QDEPTH];
	logic [bole_pkg::QAW-1:0] wr_ptr_q;
	logic [bole_pkg::QAW-1:0] rd_ptr_q;
	logic [bole_pkg::QAW:0]   fill_q;
	logic                     do_pop;

	assign full      = fill_q == (bole_pkg::QAW+1)'(bole_pkg::QDEPTH);
	assign head.vld  = fill_q != '0;
	assign head.item = slot_q[rd_ptr_q];
	assign do_pop    = pop && head.vld;

	// Pointers wrap naturally, the depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

@@ hdl/bole_back.sv @@
// Back end: executes list commands on a circular entry memory.
`default_nettype none
module bole_back #(
	parameter int DEPTH = bole_pkg::DEPTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  bole_pkg::q_head_t   head,
	output logic                pop,
	output logic                done,
	output logic [1:0]          status,
	output logic                found,
	output logic [3:0]          position,
	output logic [4:0]          entry_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW:0]   DEPTH_W = (CW+1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

	// head + offset, modulo DEPTH
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] b, input logic [CW-1:0] o);
		logic [CW:0] s;
		s = (CW+1)'(b) + {1'b0, o};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	// Control state
	bole_pkg::state_t state_q, state_nxt;
	logic [CW-1:0]    cnt_q;
	logic [AW-1:0]    head_q;
	logic             done_q;
	logic [CW-1:0]    rd_idx_q;
	logic             chk_vld_q;

	// Scan payload
	bole_pkg::op_t    op_q;
	logic [31:0]      val_q;
	logic [AW-1:0]    chk_idx_q;
	logic [CW-1:0]    w_q;
	logic             found_q;
	logic [AW-1:0]    pos_q;
	logic [31:0]      rdata_q;
	logic [31:0]      mem_q [DEPTH];

	// Result registers
	bole_pkg::status_t status_q;
	logic              found_res_q;
	logic [AW-1:0]     pos_res_q;
	logic [CW-1:0]     cnt_res_q;

	// Combinational controls
	logic              is_full, is_empty;
	logic              scan_start, issue, match, last;
	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic [31:0]       wdata;
	logic [CW-1:0]     cnt_nxt, w_nxt;
	logic [AW-1:0]     head_nxt, head_dec, head_inc;
	logic              res_fire, res_found;
	bole_pkg::status_t res_status;
	logic [AW-1:0]     res_pos;

	assign is_full  = cnt_q == DEPTH_C;
	assign is_empty = cnt_q == '0;
	assign head_dec = (head_q == '0) ? LAST_A : head_q - 1'b1;
	assign head_inc = (head_q == LAST_A) ? '0 : head_q + 1'b1;
	assign raddr    = wrap_add(head_q, rd_idx_q);
	assign match    = chk_vld_q && (rdata_q == val_q);
	assign last     = chk_vld_q && (CW'(chk_idx_q) == cnt_q - 1'b1);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bole_pkg::ST_IDLE: begin
				if (scan_start) begin
					state_nxt = bole_pkg::ST_SCAN;
				end
			end
			bole_pkg::ST_SCAN: begin
				if (last) begin
					state_nxt = bole_pkg::ST_IDLE;
				end
			end
			default: state_nxt = bole_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs and result formation
	always_comb begin
		pop        = 1'b0;
		scan_start = 1'b0;
		issue      = 1'b0;
		we         = 1'b0;
		waddr      = head_q;
		wdata      = head.item.value;
		cnt_nxt    = cnt_q;
		head_nxt   = head_q;
		w_nxt      = w_q;
		res_fire   = 1'b0;
		res_status = bole_pkg::STAT_OK;
		res_found  = 1'b0;
		res_pos    = '0;
		unique case (state_q)
			bole_pkg::ST_IDLE: begin
				if (head.vld) begin
					pop = 1'b1;
					unique case (head.item.op)
						bole_pkg::OP_PUSH_FRONT: begin
							res_fire = 1'b1;
							if (is_full) begin
								res_status = bole_pkg::STAT_FULL;
							end else begin
								we       = 1'b1;
								waddr    = head_dec;
								head_nxt = head_dec;
								cnt_nxt  = cnt_q + 1'b1;
							end
						end
						bole_pkg::OP_PUSH_BACK: begin
							res_fire = 1'b1;
							if (is_full) begin
								res_status = bole_pkg::STAT_FULL;
							end else begin
								we      = 1'b1;
								waddr   = wrap_add(head_q, cnt_q);
								cnt_nxt = cnt_q + 1'b1;
							end
						end
						bole_pkg::OP_POP_FRONT: begin
							res_fire = 1'b1;
							if (is_empty) begin
								res_status = bole_pkg::STAT_EMPTY;
							end else begin
								head_nxt = head_inc;
								cnt_nxt  = cnt_q - 1'b1;
							end
						end
						bole_pkg::OP_POP_BACK: begin
							res_fire = 1'b1;
							if (is_empty) begin
								res_status = bole_pkg::STAT_EMPTY;
							end else begin
								cnt_nxt = cnt_q - 1'b1;
							end
						end
						bole_pkg::OP_SEARCH, bole_pkg::OP_REMOVE: begin
							if (is_empty) begin
								res_fire = 1'b1;
							end else begin
								scan_start = 1'b1;
							end
						end
						default: begin
							res_fire = 1'b1;
						end
					endcase
				end
			end
			bole_pkg::ST_SCAN: begin
				issue = rd_idx_q < cnt_q;
				// remove: keep non-matching entries, compacted toward the head
				if (chk_vld_q && op_q == bole_pkg::OP_REMOVE && !match) begin
					we    = 1'b1;
					waddr = wrap_add(head_q, w_q);
					wdata = rdata_q;
					w_nxt = w_q + 1'b1;
				end
				res_found = found_q || match;
				res_pos   = found_q ? pos_q : (match ? chk_idx_q : '0);
				if (last) begin
					res_fire = 1'b1;
					if (op_q == bole_pkg::OP_REMOVE) begin
						cnt_nxt = w_nxt;
					end
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bole_pkg::ST_IDLE;
			cnt_q     <= '0;
			head_q    <= '0;
			done_q    <= 1'b0;
			rd_idx_q  <= '0;
			chk_vld_q <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			cnt_q     <= cnt_nxt;
			head_q    <= head_nxt;
			done_q    <= res_fire;
			chk_vld_q <= issue;
			if (scan_start) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// Scan payload registers
	always_ff @(posedge clk) begin
		if (scan_start) begin
			op_q    <= head.item.op;
			val_q   <= head.item.value;
			w_q     <= '0;
			found_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			w_q <= w_nxt;
			if (match && !found_q) begin
				found_q <= 1'b1;
				pos_q   <= chk_idx_q;
			end
		end
		chk_idx_q <= rd_idx_q[AW-1:0];
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (res_fire) begin
			status_q    <= res_status;
			found_res_q <= res_found;
			pos_res_q   <= res_pos;
			cnt_res_q   <= cnt_nxt;
		end
	end

	// Entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found       = found_res_q;
	assign position    = 4'(pos_res_q);
	assign entry_count = 5'(cnt_res_q);

endmodule
`default_nettype wire

@@ hdl/bounded_ordered_list_engine.sv @@
// Top level of the bounded ordered list engine.
//
//  channel   | handshake          | fields
//  ----------+--------------------+--------------------------------------------
//  command   | start / busy       | command[2:0], value[31:0] signed
//  result    | done (one cycle)   | status[1:0], found, position[3:0],
//            |                    | entry_count[4:0]
//
// A beat is taken at a clock edge with start high and busy low; each command
// gives one result beat, with done high for exactly one cycle; the receiver cannot stall.
// Pushes, pops and unused codes are finished by the back end while idle; with an
// empty queue a beat passes the front stage, the queue and the done register.
// Search and remove scan the entry memory one word a cycle through its registered
// read port on a nonempty list and hold the back end until the last entry is checked.
// Reset clears the count and the queue; entry memory has no reset.
// busy rises when the front stage holds a beat and the two-entry queue is full.
`default_nettype none
module bounded_ordered_list_engine #(
	parameter int DEPTH = bole_pkg::DEPTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire  [2:0]          command,
	input  wire  signed [31:0]  value,
	output logic                done,
	output logic [1:0]          status,
	output logic                found,
	output logic [3:0]          position,
	output logic [4:0]          entry_count
);

	logic              q_full;
	logic              q_push;
	logic              q_pop;
	bole_pkg::item_t   q_item;
	bole_pkg::q_head_t q_head;

	bole_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.command (command),
		.value   (value),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (q_item)
	);

	bole_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head)
	);

	bole_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.pop         (q_pop),
		.done        (done),
		.status      (status),
		.found       (found),
		.position    (position),
		.entry_count (entry_count)
	);

endmodule
`default_nettype wire
